// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/fvn_pkg.sv =====
// Package of constants, types and functions for the fractal value noise core.
`timescale 1ns / 1ps
package fvn_pkg;

    localparam int MaxOctaves = 8;
    localparam int FracBits   = 16;
    localparam int CoordW     = 32;
    localparam int ValW       = 16;
    localparam int OneQ16     = 65536;
    localparam int AmpW       = 17;
    localparam int SumW       = $clog2(MaxOctaves * OneQ16 + 1);
    localparam int TotW       = $clog2(MaxOctaves * OneQ16);
    localparam int OctCntW    = $clog2(MaxOctaves + 1);
    localparam int OctStages  = 6;
    localparam int OctLat     = MaxOctaves * OctStages;
    localparam int DivSteps   = ValW;
    localparam int HashShift  = 13;

    localparam logic [31:0] HashMx = 32'd374761393;
    localparam logic [31:0] HashMy = 32'd668265263;
    localparam logic [31:0] HashMf = 32'd1274126177;
    localparam logic [17:0] ThreeQ16 = 18'd196608;
    localparam logic [AmpW-1:0] AmpOne = AmpW'(OneQ16);

    localparam logic RegOctaveCount = 1'b0;
    localparam logic RegPersistence = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [TotW-1:0]   total;
    } t_oct_bus;

    typedef struct packed {
        logic            en;
        logic [AmpW-1:0] pers;
        logic [AmpW-1:0] amp;
        logic [SumW-1:0] amp_sum;
    } t_oct_ctl;

    typedef struct packed {
        logic [AmpW-1:0] amp;
        logic [SumW-1:0] amp_sum;
    } t_amp_link;

    typedef struct packed {
        logic            valid;
        logic [SumW-1:0] rem;
        logic [ValW-1:0] quo;
    } t_div_bus;

    function automatic logic [ValW-1:0] blend(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b,
                                              input logic [ValW-1:0] w);
        logic [32:0] s;
        s = 33'(a) * 33'(AmpOne - {1'b0, w}) + 33'(b) * 33'(w);
        return s[31:16];
    endfunction

endpackage

// ===== design/fvn_octave_cell.sv =====
// One octave cell: lattice hash, smoothstep, bilinear blend and weighted sum.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fvn_octave_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fvn_pkg::t_oct_bus   i_bus,
    input  fvn_pkg::t_oct_ctl   i_ctl,
    output fvn_pkg::t_oct_bus   o_bus,
    output fvn_pkg::t_amp_link  o_link
);

    localparam int S = fvn_pkg::OctStages;

    logic [S-1:0]                  r_vld;
    logic [fvn_pkg::CoordW-1:0]    r_xs [S];
    logic [fvn_pkg::CoordW-1:0]    r_ys [S];
    logic [fvn_pkg::TotW-1:0]      r_ts [S-1];
    logic [fvn_pkg::TotW-1:0]      r_tot;

    logic [31:0]                   r_ax, r_ay;
    logic [15:0]                   r_f2x, r_f2y;
    logic [17:0]                   r_tx, r_ty;
    logic [31:0]                   r_h [4];
    logic [15:0]                   r_u2, r_v2, r_u3, r_v3, r_v4;
    logic [15:0]                   r_val [4];
    logic [15:0]                   r_b0, r_b1, r_nv;
    logic [fvn_pkg::AmpW-1:0]      r_amp;
    logic [fvn_pkg::SumW-1:0]      r_sum;

    logic [31:0] w_xi, w_yi;
    logic [15:0] w_fx, w_fy;
    logic [31:0] w_fxsq, w_fysq;
    logic [33:0] w_pu, w_pv;
    logic [31:0] w_n [4];
    logic [31:0] w_m [4];
    logic [32:0] w_prod;
    logic [33:0] w_ap;

    assign w_xi   = 32'($signed(i_bus.x) >>> fvn_pkg::FracBits);
    assign w_yi   = 32'($signed(i_bus.y) >>> fvn_pkg::FracBits);
    assign w_fx   = i_bus.x[fvn_pkg::FracBits-1 -: 16];
    assign w_fy   = i_bus.y[fvn_pkg::FracBits-1 -: 16];
    assign w_fxsq = 32'(w_fx) * 32'(w_fx);
    assign w_fysq = 32'(w_fy) * 32'(w_fy);
    assign w_pu   = 34'(r_f2x) * 34'(r_tx);
    assign w_pv   = 34'(r_f2y) * 34'(r_ty);
    assign w_prod = 33'(r_nv) * 33'(i_ctl.amp);
    assign w_ap   = 34'(i_ctl.amp) * 34'(i_ctl.pers);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_n[c] = r_ax + r_ay + (c[0] ? fvn_pkg::HashMx : 32'd0)
                   + (c[1] ? fvn_pkg::HashMy : 32'd0);
            w_m[c] = r_h[c] * fvn_pkg::HashMf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_amp <= '0;
            r_sum <= '0;
        end else begin
            r_vld <= {r_vld[S-2:0], i_bus.valid};
            r_amp <= w_ap[fvn_pkg::AmpW+15:16];
            r_sum <= i_ctl.amp_sum + (i_ctl.en ? fvn_pkg::SumW'(i_ctl.amp) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs[0] <= i_bus.x;
        r_ys[0] <= i_bus.y;
        r_ts[0] <= i_bus.total;
        for (int s = 1; s < S; s++) begin
            r_xs[s] <= r_xs[s-1];
            r_ys[s] <= r_ys[s-1];
        end
        for (int s = 1; s < S - 1; s++) begin
            r_ts[s] <= r_ts[s-1];
        end

        r_ax  <= w_xi * fvn_pkg::HashMx;
        r_ay  <= w_yi * fvn_pkg::HashMy;
        r_f2x <= w_fxsq[31:16];
        r_f2y <= w_fysq[31:16];
        r_tx  <= fvn_pkg::ThreeQ16 - {1'b0, w_fx, 1'b0};
        r_ty  <= fvn_pkg::ThreeQ16 - {1'b0, w_fy, 1'b0};

        for (int c = 0; c < 4; c++) begin
            r_h[c]   <= w_n[c] ^ 32'($signed(w_n[c]) >>> fvn_pkg::HashShift);
            r_val[c] <= w_m[c][30:15];
        end
        r_u2 <= (|w_pu[33:32]) ? 16'hFFFF : w_pu[31:16];
        r_v2 <= (|w_pv[33:32]) ? 16'hFFFF : w_pv[31:16];
        r_u3 <= r_u2;
        r_v3 <= r_v2;
        r_v4 <= r_v3;

        r_b0  <= fvn_pkg::blend(r_val[0], r_val[1], r_u3);
        r_b1  <= fvn_pkg::blend(r_val[2], r_val[3], r_u3);
        r_nv  <= fvn_pkg::blend(r_b0, r_b1, r_v4);
        r_tot <= r_ts[S-2] + (i_ctl.en ? fvn_pkg::TotW'(w_prod[31:16]) : '0);
    end

    assign o_bus.valid    = r_vld[S-1];
    assign o_bus.x        = {r_xs[S-1][fvn_pkg::CoordW-2:0], 1'b0};
    assign o_bus.y        = {r_ys[S-1][fvn_pkg::CoordW-2:0], 1'b0};
    assign o_bus.total    = r_tot;
    assign o_link.amp     = r_amp;
    assign o_link.amp_sum = r_sum;

    `ASSERT_PROP(a_cell_lat, i_clk, i_rst_n, r_vld[S-1] |-> $past(i_bus.valid, S))
    `ASSERT_NEVER(a_amp_range, i_clk, i_rst_n, r_amp > fvn_pkg::AmpOne)
    `ASSERT_PROP(a_pass_hold, i_clk, i_rst_n, r_vld[1] |-> r_xs[1] == $past(i_bus.x, 2))

endmodule

// ===== design/fvn_div_cell.sv =====
// One restoring division step: shift the remainder, subtract, emit a quotient bit.
`timescale 1ns / 1ps
module fvn_div_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fvn_pkg::t_div_bus         i_bus,
    input  logic [fvn_pkg::SumW-1:0]  i_den,
    output fvn_pkg::t_div_bus         o_bus
);

    logic                         r_vld;
    logic [fvn_pkg::SumW-1:0]     r_rem;
    logic [fvn_pkg::ValW-1:0]     r_quo;
    logic [fvn_pkg::SumW:0]       w_t;
    logic [fvn_pkg::SumW:0]       w_d;
    logic                         w_ge;

    assign w_t  = {i_bus.rem, 1'b0};
    assign w_ge = (w_t >= {1'b0, i_den});
    assign w_d  = w_t - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= w_ge ? w_d[fvn_pkg::SumW-1:0] : w_t[fvn_pkg::SumW-1:0];
        r_quo <= {i_bus.quo[fvn_pkg::ValW-2:0], w_ge};
    end

    assign o_bus.valid = r_vld;
    assign o_bus.rem   = r_rem;
    assign o_bus.quo   = r_quo;

endmodule

// ===== design/fractal_value_noise_2d_core.sv =====
// Top level of the fractal value noise core: register port, octave chain, divider chain.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One point enters per clock whenever start is high; busy is always low. Each result
// appears with o_valid for one cycle once its point has passed through the 8 octave
// cells of 6 stages each, then 16 one-bit divider cells for the normalization. The
// receiver cannot stall, so it must take every result in its strobe cycle. Write the
// registers only while no point is in flight; a point may follow a write at once.
module fractal_value_noise_2d_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_x_coord,
    input  logic [31:0] i_y_coord,
    output logic        o_valid,
    output logic [15:0] o_noise_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = fvn_pkg::MaxOctaves;
    localparam int D = fvn_pkg::DivSteps;

    logic [3:0]                   r_octave_count;
    logic [fvn_pkg::AmpW-1:0]     r_persistence;

    logic                         w_wr;
    logic                         w_accept;
    logic [fvn_pkg::OctCntW-1:0]  w_oct_n;
    logic [fvn_pkg::AmpW-1:0]     w_pers;

    fvn_pkg::t_oct_bus  w_bus  [N+1];
    fvn_pkg::t_amp_link w_link [N+1];
    fvn_pkg::t_oct_ctl  w_ctl  [N];
    fvn_pkg::t_div_bus  w_div  [D+1];

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign w_wr     = psel && penable && pwrite && pready;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= 4'd4;
            r_persistence  <= fvn_pkg::AmpW'(32768);
        end else if (w_wr) begin
            case (paddr[2])
                fvn_pkg::RegOctaveCount: r_octave_count <= pwdata[3:0];
                fvn_pkg::RegPersistence: r_persistence  <= pwdata[fvn_pkg::AmpW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fvn_pkg::RegOctaveCount: prdata = {28'd0, r_octave_count};
            fvn_pkg::RegPersistence: prdata = {15'd0, r_persistence};
            default:                 prdata = '0;
        endcase
    end

    always_comb begin
        if (r_octave_count == 4'd0) begin
            w_oct_n = fvn_pkg::OctCntW'(1);
        end else if (32'(r_octave_count) > N) begin
            w_oct_n = fvn_pkg::OctCntW'(N);
        end else begin
            w_oct_n = fvn_pkg::OctCntW'(r_octave_count);
        end
        w_pers = (r_persistence > fvn_pkg::AmpOne) ? fvn_pkg::AmpOne : r_persistence;
    end

    assign w_bus[0].valid     = w_accept;
    assign w_bus[0].x         = i_x_coord;
    assign w_bus[0].y         = i_y_coord;
    assign w_bus[0].total     = '0;
    assign w_link[0].amp      = fvn_pkg::AmpOne;
    assign w_link[0].amp_sum  = '0;

    for (genvar k = 0; k < N; k++) begin : g_oct
        assign w_ctl[k].en      = (fvn_pkg::OctCntW'(k) < w_oct_n);
        assign w_ctl[k].pers    = w_pers;
        assign w_ctl[k].amp     = w_link[k].amp;
        assign w_ctl[k].amp_sum = w_link[k].amp_sum;

        fvn_octave_cell u_oct (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_bus[k]),
            .i_ctl   (w_ctl[k]),
            .o_bus   (w_bus[k+1]),
            .o_link  (w_link[k+1])
        );
    end

    assign w_div[0].valid = w_bus[N].valid;
    assign w_div[0].rem   = fvn_pkg::SumW'(w_bus[N].total);
    assign w_div[0].quo   = '0;

    for (genvar j = 0; j < D; j++) begin : g_div
        fvn_div_cell u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_div[j]),
            .i_den   (w_link[N].amp_sum),
            .o_bus   (w_div[j+1])
        );
    end

    assign o_valid       = w_div[D].valid;
    assign o_noise_value = w_div[D].quo;

    `ASSERT_PROP(a_oct_lat, i_clk, i_rst_n, w_div[0].valid |-> $past(w_accept, fvn_pkg::OctLat))
    `ASSERT_PROP(a_div_lat, i_clk, i_rst_n, o_valid |-> $past(w_div[0].valid, D))
    `ASSERT_PROP(a_den_set, i_clk, i_rst_n, o_valid |-> w_link[N].amp_sum != '0)

endmodule

// ===== bench/fvn_checker.sv =====
// Checker for the fractal value noise core: predicts each noise value and compares it.
`timescale 1ns / 1ps
module fvn_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_x_coord,
    input  logic [31:0] i_y_coord,
    input  logic        o_valid,
    input  logic [15:0] o_noise_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int ShownMax = 10;

    logic [3:0]  octaves_q;
    logic [16:0] persist_q;
    logic [15:0] noise_q[$];
    int          fail_count;

    function automatic logic [15:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
        logic [31:0] n;
        n = cx * fvn_pkg::HashMx + cy * fvn_pkg::HashMy;
        n = (n ^ 32'($signed(n) >>> fvn_pkg::HashShift)) * fvn_pkg::HashMf;
        return n[30:15];
    endfunction

    function automatic logic [15:0] smooth_weight(logic [15:0] f);
        logic [63:0] f2;
        logic [63:0] t;
        logic [63:0] w;
        f2 = (64'(f) * 64'(f)) >> 16;
        t  = 64'd196608 - 2 * 64'(f);
        w  = (f2 * t) >> 16;
        return (w > 64'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [15:0] mix(logic [15:0] a, logic [15:0] b, logic [15:0] w);
        logic [63:0] s;
        s = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
        return s[31:16];
    endfunction

    function automatic logic [15:0] octave_noise(logic [31:0] px, logic [31:0] py);
        logic [31:0] xi;
        logic [31:0] yi;
        logic [15:0] u;
        logic [15:0] v;
        xi = 32'($signed(px) >>> 16);
        yi = 32'($signed(py) >>> 16);
        u  = smooth_weight(px[15:0]);
        v  = smooth_weight(py[15:0]);
        return mix(mix(lattice_hash(xi, yi), lattice_hash(xi + 1, yi), u),
                   mix(lattice_hash(xi, yi + 1), lattice_hash(xi + 1, yi + 1), u), v);
    endfunction

    function automatic logic [15:0] fractal_noise(logic [31:0] x, logic [31:0] y);
        int          n;
        logic [63:0] p;
        logic [63:0] amp;
        logic [63:0] amp_sum;
        logic [63:0] total;
        logic [63:0] r;
        n = (octaves_q < 1) ? 1 : ((octaves_q > 8) ? 8 : int'(octaves_q));
        p = (persist_q > 17'd65536) ? 64'd65536 : 64'(persist_q);
        amp = 64'd65536;
        amp_sum = 0;
        total = 0;
        for (int i = 0; i < n; i++) begin
            total += (64'(octave_noise(x << i, y << i)) * amp) >> 16;
            amp_sum += amp;
            amp = (amp * p) >> 16;
        end
        r = (total << 16) / amp_sum;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            octaves_q  <= 4'd4;
            persist_q  <= 17'd32768;
            noise_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == fvn_pkg::RegPersistence) begin
                    persist_q <= pwdata[16:0];
                end else begin
                    octaves_q <= pwdata[3:0];
                end
            end
            if (start && !busy) begin
                noise_q.push_back(fractal_noise(i_x_coord, i_y_coord));
            end
            if (o_valid) begin
                if (noise_q.size() == 0) begin
                    if (fail_count < ShownMax) begin
                        $display("unexpected result noise=%h", o_noise_value);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    if (noise_q[0] !== o_noise_value) begin
                        if (fail_count < ShownMax) begin
                            $display("noise mismatch: expected %h actual %h",
                                     noise_q[0], o_noise_value);
                        end
                        fail_count <= fail_count + 1;
                    end
                    void'(noise_q.pop_front());
                end
            end
        end
    end

    assign o_fail_count = fail_count + ((noise_q.size() != 0) ? 0 : 0);
    assign o_pending = noise_q.size();
endmodule

// ===== bench/testbench.sv =====
// Top of the bench: drives points and register writes into the noise core.
`timescale 1ns / 1ps
module testbench;

    localparam int WatchLimit = 2000;
    localparam int DrainCycles = 80;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [31:0] i_x_coord = 0;
    logic [31:0] i_y_coord = 0;
    logic        o_valid;
    logic [15:0] o_noise_value;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm;

    always #5 i_clk = ~i_clk;

    fractal_value_noise_2d_core u_dut (.*);

    fvn_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_x_coord, .i_y_coord, .o_valid,
        .o_noise_value, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        repeat (4) @(negedge i_clk);
    endtask

    task automatic drain;
        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        while (!calm && $urandom_range(99) < 29) begin
            start = 0;
            @(negedge i_clk);
        end
        start = 1;
        i_x_coord = x;
        i_y_coord = y;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [31:0] octaves, logic [31:0] persist);
        start = 0;
        drain();
        write_reg({fvn_pkg::RegOctaveCount, 2'b00}, octaves);
        write_reg({fvn_pkg::RegPersistence, 2'b00}, persist);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return {16'($urandom_range(7)), 16'($urandom())};
        endcase
    endfunction

    initial begin
        logic [31:0] corners[6];
        logic [31:0] octs[5];
        logic [31:0] pers[5];
        corners = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0000FFFF, 32'h00010000};
        octs = '{0, 1, 8, 15, 3};
        pers = '{0, 65536, 131071, 12345, 50000};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;
        calm = 1;
        for (int i = 0; i < 6; i++) begin
            send_point(corners[i], corners[5 - i]);
            send_point(corners[i], corners[i]);
        end
        send_point(32'h7FFF8000, 32'h8000C000);
        configure(8, 65536);
        send_point(32'h7FFFFFFF, 32'h40000000);
        send_point(32'hC0000001, 32'h00018000);
        for (int c = 0; c < 5; c++) begin
            configure(octs[c], pers[c]);
            calm = (c == 2);
            for (int k = 0; k < 390; k++) begin
                send_point(rand_coord(), rand_coord());
            end
        end
        start = 0;
        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
